>>> rtl/debl_pkg.sv
// ----------------------------------------------------------------------------
// Bus break locator package
// Shared widths, reset values, register indexes and the types that travel
// between the lifetime tracker, the classifier and the top level.
// ----------------------------------------------------------------------------
package debl_pkg;

	localparam int MAX_SLOTS_DEF = 8;
	localparam int LIFE_LOAD_DEF = 3;

	localparam int ID_W          = 6;
	localparam int COUNT_W       = 4;
	localparam int WIRING_W      = 48;
	localparam int FRAME_ID_W    = 29;
	localparam int MASK_W        = 8;
	localparam int BRK_W         = 5;
	localparam int MOTOR_W       = 7;
	localparam int LIFE_W        = 2;
	localparam int FIRST_ID      = 10;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0]  MOTOR_COUNT_RST = 4'd6;
	localparam logic [WIRING_W-1:0] WIRING_IDS_RST  = 48'd15304020682;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTOR_COUNT = 1'b0,
		REG_WIRING_IDS  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_FRAME = 1'b0,
		REQ_TICK  = 1'b1
	} req_type_t;

	typedef enum logic {
		SIDE_1 = 1'b0,
		SIDE_2 = 1'b1
	} bus_side_t;

	// Update request from the input stage to the lifetime counters.
	typedef struct packed {
		logic              valid;
		req_type_t         kind;
		bus_side_t         side;
		logic [ID_W-1:0]   id;
	} life_cmd_t;

	// First member lands in the highest bits, so the last one listed is the
	// lowest field on the output bus.
	typedef struct packed {
		logic [MASK_W-1:0]         dead_by_id;
		logic [MASK_W-1:0]         only_side2_by_id;
		logic [MASK_W-1:0]         seen_side2_by_id;
		logic [MASK_W-1:0]         seen_side1_by_id;
		logic signed [MOTOR_W-1:0] right_motor;
		logic signed [MOTOR_W-1:0] left_motor;
		logic signed [BRK_W-1:0]   break_count;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

>>> rtl/debl_life.sv
// ----------------------------------------------------------------------------
// Lifetime counters
// One small down-counter per wiring slot and bus side. A frame reloads the
// counter of the highest matching slot; a tick decays every nonzero counter.
// ----------------------------------------------------------------------------
module debl_life import debl_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int LIFE_LOAD = LIFE_LOAD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  life_cmd_t                        cmd,
	input  logic [MAX_SLOTS-1:0]             slot_en,
	input  logic [MAX_SLOTS-1:0][ID_W-1:0]   slot_ids,
	output logic [MAX_SLOTS-1:0]             vis1,
	output logic [MAX_SLOTS-1:0]             vis2
);

	localparam logic [LIFE_W-1:0] LOAD_VAL = LIFE_W'(LIFE_LOAD);

	logic [MAX_SLOTS-1:0][LIFE_W-1:0] life1_q;
	logic [MAX_SLOTS-1:0][LIFE_W-1:0] life2_q;
	logic [MAX_SLOTS-1:0]             hit;

	// Only the highest matching slot takes the reload.
	always_comb begin
		hit = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (slot_en[i] && slot_ids[i] == cmd.id) begin
				hit    = '0;
				hit[i] = 1'b1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			vis1[i] = life1_q[i] != '0;
			vis2[i] = life2_q[i] != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life1_q <= '0;
			life2_q <= '0;
		end else if (cmd.valid) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				if (cmd.kind == REQ_TICK) begin
					if (vis1[i]) life1_q[i] <= life1_q[i] - LIFE_W'(1);
					if (vis2[i]) life2_q[i] <= life2_q[i] - LIFE_W'(1);
				end else if (hit[i]) begin
					if (cmd.side == SIDE_2) life2_q[i] <= LOAD_VAL;
					else life1_q[i] <= LOAD_VAL;
				end
			end
		end
	end

endmodule

>>> rtl/debl_classify.sv
// ----------------------------------------------------------------------------
// Chain classifier
// Turns one visibility snapshot into the break count, the motors bounding a
// single break and the per-id visibility masks.
// ----------------------------------------------------------------------------
module debl_classify import debl_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic [MAX_SLOTS-1:0]            vis1,
	input  logic [MAX_SLOTS-1:0]            vis2,
	input  logic [MAX_SLOTS-1:0]            slot_en,
	input  logic [MAX_SLOTS-1:0][ID_W-1:0]  slot_ids,
	input  logic [COUNT_W-1:0]              n_eff,
	output result_t                         res
);

	localparam logic signed [MOTOR_W-1:0] NO_MOTOR = '1;
	localparam logic signed [BRK_W-1:0]   BRK_NONE = '1;

	logic [MAX_SLOTS-1:0] pre1, suf2, live, prev;
	logic                 all1, all2, none1, none2;
	logic [COUNT_W-1:0]   pre_len, suf_len, edges;
	logic                 single;
	logic [ID_W-1:0]      first_id, last_id, pre_last_id, pre_next_id;
	logic                 pre_any, pre_short;

	always_comb begin
		all1  = &(vis1 | ~slot_en);
		all2  = &(vis2 | ~slot_en);
		none1 = ~|(vis1 & slot_en);
		none2 = ~|(vis2 & slot_en);

		// Leading run seen from side 1 and trailing run seen from side 2.
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (i == 0) pre1[i] = vis1[i];
			else pre1[i] = pre1[i-1] & vis1[i];
		end
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (i == MAX_SLOTS - 1) suf2[i] = vis2[i] | ~slot_en[i];
			else suf2[i] = suf2[i+1] & (vis2[i] | ~slot_en[i]);
		end
		pre_len = COUNT_W'($countones(pre1 & slot_en));
		suf_len = COUNT_W'($countones(suf2 & slot_en));
		single  = ({1'b0, pre_len} + {1'b0, suf_len}) == {1'b0, n_eff};

		// Combined visibility changes, with a visible state assumed before slot 0.
		live = vis1 | vis2;
		prev = {live[MAX_SLOTS-1:0] << 1} | MAX_SLOTS'(1);
		edges = COUNT_W'($countones((live ^ prev) & slot_en));

		first_id    = slot_ids[0];
		last_id     = slot_ids[0];
		pre_last_id = slot_ids[0];
		pre_next_id = slot_ids[0];
		pre_any     = 1'b0;
		pre_short   = 1'b0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (slot_en[i]) last_id = slot_ids[i];
			if (slot_en[i] && pre1[i]) begin
				pre_last_id = slot_ids[i];
				pre_any     = 1'b1;
			end
		end
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (slot_en[i] && !pre1[i]) begin
				pre_next_id = slot_ids[i];
				pre_short   = 1'b1;
			end
		end

		res.break_count = '0;
		res.left_motor  = NO_MOTOR;
		res.right_motor = NO_MOTOR;
		priority if (all1 && all2) begin
			res.break_count = '0;
		end else if (none1 && none2) begin
			res.break_count = BRK_NONE;
		end else if (none1) begin
			res.break_count = BRK_W'(1);
			res.right_motor = {1'b0, first_id};
		end else if (none2) begin
			res.break_count = BRK_W'(1);
			res.left_motor  = {1'b0, last_id};
		end else if (single) begin
			res.break_count = BRK_W'(1);
			if (pre_any) res.left_motor = {1'b0, pre_last_id};
			if (pre_short) res.right_motor = {1'b0, pre_next_id};
		end else begin
			res.break_count = {1'b0, edges};
		end

		// Per-id masks; a later slot with the same id overrides an earlier one.
		res.seen_side1_by_id = '0;
		res.seen_side2_by_id = '0;
		res.only_side2_by_id = '0;
		res.dead_by_id       = '1;
		for (int k = 0; k < MASK_W; k++) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				if (k < MAX_SLOTS && slot_en[i] && slot_ids[i] == ID_W'(FIRST_ID + k)) begin
					res.seen_side1_by_id[k] = vis1[i];
					res.seen_side2_by_id[k] = vis2[i];
					res.only_side2_by_id[k] = !vis1[i] && vis2[i];
					res.dead_by_id[k]       = !vis1[i] && !vis2[i];
				end
			end
		end
	end

endmodule

>>> rtl/dual_ended_bus_break_locator.sv
// ----------------------------------------------------------------------------
// Dual-ended bus break locator
// Tracks which motors of a daisy-chained bus are heard from each end and
// reports where the chain is broken on every status tick.
// ----------------------------------------------------------------------------
// One transaction enters per clock unless the input side is stalled. A
// transaction is held in the input register, where a frame reloads its slot's
// lifetime counter and a tick snapshots and decays all counters and is
// classified in the same cycle; the tick's result is then registered into the
// head or skid entry of the output queue, and frames produce no output. A
// two-entry output queue lets input flow on while results wait; only a tick
// held in the input register with the queue full stops the input side.
module dual_ended_bus_break_locator import debl_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int LIFE_LOAD = LIFE_LOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // frame_id[28:0], zero pad
	input  logic [S_TUSER_W-1:0]  s_tuser,   // req_type[0], bus_side[1]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// break_count[4:0], left_motor[11:5], right_motor[18:12],
	// seen_side1_by_id[26:19], seen_side2_by_id[34:27],
	// only_side2_by_id[42:35], dead_by_id[50:43], zero pad
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WIRING_W-1:0]   cfg_data
);

	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SLOTS);

	logic [COUNT_W-1:0]  motor_count_q;
	logic [WIRING_W-1:0] wiring_ids_q;

	logic             valid_s1;
	req_type_t        kind_s1;
	bus_side_t        side_s1;
	logic [ID_W-1:0]  id_s1;

	logic    head_valid_q, skid_valid_q;
	result_t head_q, skid_q;

	logic                            tick_s1, stall, advance, push, pop;
	logic [COUNT_W-1:0]              n_eff;
	logic [MAX_SLOTS-1:0]            slot_en;
	logic [MAX_SLOTS-1:0][ID_W-1:0]  slot_ids;
	logic [MAX_SLOTS-1:0]            vis1, vis2;
	life_cmd_t                       life_cmd;
	result_t                         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_count_q <= MOTOR_COUNT_RST;
			wiring_ids_q  <= WIRING_IDS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MOTOR_COUNT: motor_count_q <= cfg_data[COUNT_W-1:0];
				REG_WIRING_IDS:  wiring_ids_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (motor_count_q == '0) n_eff = COUNT_W'(1);
		else if (motor_count_q > MAX_CNT) n_eff = MAX_CNT;
		else n_eff = motor_count_q;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_ids[i] = wiring_ids_q[ID_W*i +: ID_W];
			slot_en[i]  = COUNT_W'(i) < n_eff;
		end
	end

	// Input register.
	assign tick_s1  = valid_s1 && kind_s1 == REQ_TICK;
	assign stall    = tick_s1 && skid_valid_q;
	assign advance  = valid_s1 && !stall;
	assign s_tready = !valid_s1 || !stall;
	assign push     = tick_s1 && !skid_valid_q;
	assign pop      = head_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= req_type_t'(s_tuser[0]);
			side_s1 <= bus_side_t'(s_tuser[1]);
			id_s1   <= s_tdata[ID_W-1:0];
		end
	end

	assign life_cmd = '{valid: advance, kind: kind_s1, side: side_s1, id: id_s1};

	debl_life #(
		.MAX_SLOTS (MAX_SLOTS),
		.LIFE_LOAD (LIFE_LOAD)
	) u_life (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (life_cmd),
		.slot_en  (slot_en),
		.slot_ids (slot_ids),
		.vis1     (vis1),
		.vis2     (vis2)
	);

	debl_classify #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_classify (
		.vis1     (vis1),
		.vis2     (vis2),
		.slot_en  (slot_en),
		.slot_ids (slot_ids),
		.n_eff    (n_eff),
		.res      (res)
	);

	// Two-entry output queue; the skid entry is only ever filled behind the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				head_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= head_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) head_q <= skid_q;
			else if (push) head_q <= res;
		end else if (push) begin
			if (head_valid_q) skid_q <= res;
			else head_q <= res;
		end
	end

	assign m_tvalid = head_valid_q;
	assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), head_q};

	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> head_valid_q)
		else $error("skid entry valid without a head entry");

	a_tick_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> m_tvalid)
		else $error("classified tick did not reach the output");

	a_frame_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && kind_s1 == REQ_FRAME && !pop) |=> $stable(head_valid_q))
		else $error("frame changed the output queue");

	a_power_fail_no_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && head_q.break_count == BRK_W'(-1)) |->
		(head_q.left_motor == MOTOR_W'(-1) && head_q.right_motor == MOTOR_W'(-1)))
		else $error("power failure reported with a bounding motor");

	a_masks_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((head_q.dead_by_id & head_q.seen_side1_by_id) == '0 &&
		(head_q.only_side2_by_id & head_q.seen_side1_by_id) == '0))
		else $error("visibility masks overlap");

endmodule

>>> dv/tb_dual_ended_bus_break_locator.sv
// ----------------------------------------------------------------------------
// Testbench for the dual-ended bus break locator
// Streams bus frames and status ticks into the block under several wiring
// setups. A behavioral copy of the lifetime counters and the classifier
// predicts every tick report, and each report is compared field by field.
// ----------------------------------------------------------------------------
module tb_dual_ended_bus_break_locator;
	import debl_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [LIFE_W-1:0] LIFE_RELOAD = LIFE_W'(LIFE_LOAD_DEF);

	typedef struct {
		req_type_t         kind;
		bus_side_t         side;
		logic [FRAME_ID_W-1:0] fid;
	} bus_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WIRING_W-1:0]  cfg_data = '0;

	// Behavioral copy of the block's registers and lifetime counters.
	logic [COUNT_W-1:0]  cfg_motor_count = MOTOR_COUNT_RST;
	logic [WIRING_W-1:0] cfg_wiring = WIRING_IDS_RST;
	logic [LIFE_W-1:0]   life1 [MAX_SLOTS_DEF] = '{default: '0};
	logic [LIFE_W-1:0]   life2 [MAX_SLOTS_DEF] = '{default: '0};

	bus_item_t bus_items [$];
	result_t   break_reports_due [$];
	bus_item_t cur_item;
	logic      calm = 1'b0;
	int        err_count = 0;
	int        stall_cycles = 0;

	dual_ended_bus_break_locator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_slots();
		int n;
		n = cfg_motor_count;
		if (n < 1) n = 1;
		if (n > MAX_SLOTS_DEF) n = MAX_SLOTS_DEF;
		return n;
	endfunction

	function automatic logic [ID_W-1:0] slot_id(input int k);
		return cfg_wiring[ID_W*k +: ID_W];
	endfunction

	// Applies one accepted transaction to the counters; a tick also queues
	// the report the block must produce for it.
	task automatic advance_locator(input bus_item_t it);
		int n, n1, n2, hit, last1, first2, brk, left, right;
		logic [ID_W-1:0]   id;
		logic [MASK_W-1:0] vis1, vis2, s1, s2, o2, dead, b;
		logic prev, cur;
		result_t r;
		n = eff_slots();
		if (it.kind == REQ_FRAME) begin
			id = it.fid[ID_W-1:0];
			hit = -1;
			for (int i = 0; i < n; i++)
				if (slot_id(i) == id) hit = i;
			if (hit >= 0) begin
				if (it.side == SIDE_2) life2[hit] = LIFE_RELOAD;
				else life1[hit] = LIFE_RELOAD;
			end
			return;
		end

		for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
			vis1[i] = life1[i] != 0;
			vis2[i] = life2[i] != 0;
			if (life1[i] != 0) life1[i] = life1[i] - 1'b1;
			if (life2[i] != 0) life2[i] = life2[i] - 1'b1;
		end
		n1 = 0;
		n2 = 0;
		for (int i = 0; i < n; i++) begin
			n1 += vis1[i];
			n2 += vis2[i];
		end

		brk = 0;
		left = -1;
		right = -1;
		if (n1 == n && n2 == n) begin
			brk = 0;
		end else if (n1 == 0 && n2 == 0) begin
			brk = -1;
		end else if (n1 == 0) begin
			brk = 1;
			right = slot_id(0);
		end else if (n2 == 0) begin
			brk = 1;
			left = slot_id(n - 1);
		end else begin
			last1 = -1;
			first2 = n;
			for (int i = 0; i < n && vis1[i]; i++) last1 = i;
			for (int k = n - 1; k >= 0 && vis2[k]; k--) first2 = k;
			if (last1 + 1 == first2) begin
				brk = 1;
				if (last1 >= 0) left = slot_id(last1);
				if (first2 < n) right = slot_id(first2);
			end else begin
				// Count visibility changes along the chain, starting visible.
				prev = 1'b1;
				for (int i = 0; i < n; i++) begin
					cur = vis1[i] | vis2[i];
					if (cur != prev) brk++;
					prev = cur;
				end
			end
		end

		s1 = '0;
		s2 = '0;
		o2 = '0;
		dead = '1;
		for (int i = 0; i < n; i++) begin
			id = slot_id(i);
			if (id >= FIRST_ID && id < FIRST_ID + MASK_W) begin
				b = MASK_W'(1) << (id - FIRST_ID);
				s1 = vis1[i] ? (s1 | b) : (s1 & ~b);
				s2 = vis2[i] ? (s2 | b) : (s2 & ~b);
				o2 = (!vis1[i] && vis2[i]) ? (o2 | b) : (o2 & ~b);
				dead = (!vis1[i] && !vis2[i]) ? (dead | b) : (dead & ~b);
			end
		end

		r.break_count = brk[BRK_W-1:0];
		r.left_motor = left[MOTOR_W-1:0];
		r.right_motor = right[MOTOR_W-1:0];
		r.seen_side1_by_id = s1;
		r.seen_side2_by_id = s2;
		r.only_side2_by_id = o2;
		r.dead_by_id = dead;
		break_reports_due.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		err_count++;
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want) report_mismatch(what, got, want);
	endtask

	// Driver: holds a transaction until it is taken, then loads the next one.
	always @(posedge clk) begin
		bus_item_t nxt;
		logic      load;
		if (arst_n) begin
			if (s_tvalid && s_tready) advance_locator(cur_item);
			if (!s_tvalid || s_tready) begin
				load = bus_items.size() != 0 && (calm || $urandom_range(0, 99) >= 6);
				if (load) begin
					nxt = bus_items.pop_front();
					cur_item <= nxt;
					s_tdata <= {{(S_TDATA_W - FRAME_ID_W){1'b0}}, nxt.fid};
					s_tuser <= {nxt.side, nxt.kind};
				end
				s_tvalid <= load;
			end
		end
	end

	// Monitor: compares every report taken with the oldest one predicted.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[RESULT_W-1:0];
				if (break_reports_due.size() == 0) begin
					report_mismatch("report count (no report due)", 1, 0);
				end else begin
					want = break_reports_due.pop_front();
					check_field("break_count", $signed(got.break_count),
						$signed(want.break_count));
					check_field("left_motor", $signed(got.left_motor),
						$signed(want.left_motor));
					check_field("right_motor", $signed(got.right_motor),
						$signed(want.right_motor));
					check_field("seen_side1_by_id", got.seen_side1_by_id,
						want.seen_side1_by_id);
					check_field("seen_side2_by_id", got.seen_side2_by_id,
						want.seen_side2_by_id);
					check_field("only_side2_by_id", got.only_side2_by_id,
						want.only_side2_by_id);
					check_field("dead_by_id", got.dead_by_id, want.dead_by_id);
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 6);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_frame(input bus_side_t side, input logic [FRAME_ID_W-1:0] fid);
		bus_item_t it;
		it.kind = REQ_FRAME;
		it.side = side;
		it.fid = fid;
		bus_items.push_back(it);
	endtask

	task automatic queue_slot(input bus_side_t side, input int k);
		logic [31:0] upper;
		upper = $urandom;
		queue_frame(side, {upper[FRAME_ID_W-ID_W-1:0], slot_id(k)});
	endtask

	task automatic queue_tick();
		bus_item_t it;
		logic [31:0] junk;
		junk = $urandom;
		it.kind = REQ_TICK;
		it.side = bus_side_t'(junk[31]);
		it.fid = junk[FRAME_ID_W-1:0];
		bus_items.push_back(it);
	endtask

	// Each round lights a chosen visibility pattern, then ticks. Three ticks
	// let every counter run out, so most rounds start from a clean chain.
	task automatic queue_rounds(input int target);
		int n, b, b2, mode, ticks, start;
		logic [MASK_W-1:0] m1, m2;
		logic [31:0] r;
		n = eff_slots();
		start = bus_items.size();
		while (bus_items.size() - start < target) begin
			mode = $urandom_range(0, 9);
			b = $urandom_range(0, n);
			b2 = (mode == 4) ? $urandom_range(0, b) : b;
			m1 = '0;
			m2 = '0;
			case (mode)
				0, 1, 2, 3, 4: begin
					for (int i = 0; i < n; i++) begin
						m1[i] = i < b;
						m2[i] = i >= b2;
					end
				end
				5: begin
					// One side hears everything, the other misses its own end.
					if ($urandom_range(0, 1)) begin
						m1 = MASK_W'($urandom) & ~MASK_W'(1);
						m2 = '1;
					end else begin
						m1 = '1;
						m2 = MASK_W'($urandom);
						m2[n-1] = 1'b0;
					end
				end
				6: begin
					m1 = MASK_W'($urandom);
					m2 = MASK_W'($urandom);
				end
				8: begin
					repeat ($urandom_range(1, 4)) begin
						r = $urandom;
						queue_frame(bus_side_t'(r[31]), r[FRAME_ID_W-1:0]);
					end
				end
				9: begin
					m1 = '1;
					m2 = '1;
				end
				default: ;
			endcase
			for (int i = 0; i < n; i++) begin
				if (m1[i]) queue_slot(SIDE_1, i);
				if (m2[i]) queue_slot(SIDE_2, i);
			end
			ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 3;
			repeat (ticks) queue_tick();
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [WIRING_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MOTOR_COUNT) cfg_motor_count = val[COUNT_W-1:0];
		else cfg_wiring = val;
	endtask

	// The test waits until every item is sent and every report due has arrived;
	// frames leave no report, so a settling wait at the end lets the last one settle.
	task automatic drain();
		while (bus_items.size() != 0 || s_tvalid || break_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [COUNT_W-1:0]  mc;
		logic [WIRING_W-1:0] wr;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset wiring (six motors).
		queue_tick();                              // nothing heard: power failure
		queue_frame(SIDE_1, '0);                   // id 0 is not wired
		queue_frame(SIDE_2, '1);                   // id 63 is not wired
		queue_slot(SIDE_1, 0);
		queue_slot(SIDE_1, 1);
		for (int k = 2; k < 6; k++) queue_slot(SIDE_2, k);
		queue_tick();                              // one break between slots 1 and 2
		for (int k = 2; k < 6; k++) queue_slot(SIDE_1, k);
		queue_tick();                              // all reachable, yet not all seen twice
		repeat (4) queue_tick();                   // decay back to power failure
		queue_slot(SIDE_2, 0);
		queue_tick();                              // side 1 blind
		queue_slot(SIDE_1, 5);
		queue_tick();                              // each side sees only the far end
		drain();

		for (int p = 0; p < 10; p++) begin
			wr = '0;
			case (p)
				0: begin
					mc = 4'd8;
					for (int k = 0; k < 8; k++) wr[6*k +: 6] = 6'(FIRST_ID + k);
				end
				1: begin
					mc = 4'd1;
					wr = WIRING_W'({$urandom, $urandom});
					wr[5:0] = 6'(FIRST_ID);
				end
				2: begin
					mc = 4'd0;
					wr = WIRING_W'({$urandom, $urandom});
				end
				3: begin
					mc = 4'd15;
					for (int k = 0; k < 8; k++) wr[6*k +: 6] = 6'(FIRST_ID + 7 - k);
				end
				4: begin
					mc = 4'd9;
					wr = '1;
				end
				5: begin
					mc = 4'd3;
					wr = '0;
				end
				6: begin
					mc = 4'd8;
					for (int k = 0; k < 8; k++)
						wr[6*k +: 6] = 6'(FIRST_ID + $urandom_range(0, 3));
				end
				7: begin
					mc = 4'($urandom_range(1, 8));
					for (int k = 0; k < 8; k++)
						wr[6*k +: 6] = 6'(FIRST_ID + $urandom_range(0, 7));
				end
				8: begin
					mc = 4'($urandom_range(0, 15));
					wr = WIRING_W'({$urandom, $urandom});
				end
				default: begin
					mc = MOTOR_COUNT_RST;
					wr = WIRING_IDS_RST;
				end
			endcase
			write_reg(REG_MOTOR_COUNT, {{(WIRING_W - COUNT_W){1'b0}}, mc});
			write_reg(REG_WIRING_IDS, wr);
			calm = (p == 3);
			queue_rounds(55);
			drain();
		end

		if (err_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/debl_pkg.sv
rtl/debl_life.sv
rtl/debl_classify.sv
rtl/dual_ended_bus_break_locator.sv
dv/tb_dual_ended_bus_break_locator.sv
